FILE: sv/tobp_pkg.sv
package tobp_pkg;

   // Default geometry of the line and of the history ring
   localparam int unsigned LINE_COLS_DEF = 88;
   localparam int unsigned RING_ROWS_DEF = 2048;

   // Result field widths
   localparam int unsigned ROW_W  = 11;
   localparam int unsigned COL_W  = 7;
   localparam int unsigned CHAR_W = 8;
   localparam int unsigned LEN_W  = 7;

   // Byte codes
   localparam logic [7:0] BYTE_ESC   = 8'h1B;
   localparam logic [7:0] BYTE_CR    = 8'h0D;
   localparam logic [7:0] BYTE_LF    = 8'h0A;
   localparam logic [7:0] BYTE_BS    = 8'h08;
   localparam logic [7:0] BYTE_TAB   = 8'h09;
   localparam logic [7:0] BYTE_DEL   = 8'h7F;
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_IMED  = 8'h2F;
   localparam logic [7:0] BYTE_FLO   = 8'h40;
   localparam logic [7:0] BYTE_FHI   = 8'h7E;
   localparam logic [7:0] BYTE_ZERO  = 8'h30;
   localparam logic [7:0] BYTE_NINE  = 8'h39;
   localparam logic [7:0] BYTE_SEMI  = 8'h3B;
   localparam logic [7:0] BYTE_K     = 8'h4B;
   localparam logic [7:0] BYTE_LBRK  = 8'h5B;

   typedef enum logic [2:0] {
      ACT_ABSORB  = 3'd0,
      ACT_PLACE   = 3'd1,
      ACT_SHORTEN = 3'd2,
      ACT_CLEAR   = 3'd3,
      ACT_COMMIT  = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      PH_NORMAL = 2'd0,
      PH_ESC    = 2'd1,
      PH_CSI    = 2'd2
   } phase_type;

   // What one byte does to the line
   typedef enum logic [2:0] {
      EV_ABSORB,
      EV_CSI_CLEAR,
      EV_LF_COMMIT,
      EV_CR_CLEAR,
      EV_CR_CLEAR_PLACE,
      EV_SHORTEN,
      EV_PLACE,
      EV_WRAP_PLACE
   } event_type;

   typedef struct packed {
      logic [LEN_W-1:0]  line_length;
      logic [CHAR_W-1:0] character;
      logic [COL_W-1:0]  column;
      logic [ROW_W-1:0]  row;
      action_type        action;
      logic              last;
   } result_type;

endpackage

FILE: sv/tobp_core.sv
module tobp_core #(
   parameter int unsigned LINE_COLS = tobp_pkg::LINE_COLS_DEF,
   parameter int unsigned RING_ROWS = tobp_pkg::RING_ROWS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          byte_in,
   output tobp_pkg::result_type res0,
   output tobp_pkg::result_type res1,
   output logic                two
);
   import tobp_pkg::*;

   localparam int unsigned RowW   = (RING_ROWS > 1) ? $clog2(RING_ROWS) : 1;
   localparam int unsigned LenW   = $clog2(LINE_COLS + 1);
   localparam int unsigned RowExt = (RowW > ROW_W) ? RowW : ROW_W;
   localparam int unsigned LenExt = (LenW > LEN_W) ? LenW : LEN_W;

   phase_type        phase_ff, phase_in;
   logic             cr_ff, cr_in;
   logic [LenW-1:0]  len_ff, len_in;
   logic [RowW-1:0]  row_ff, row_in;

   logic [RowW-1:0]  row_next;
   logic [LenW-1:0]  len_dec, len_inc;
   logic [RowExt-1:0] cur_row_x, next_row_x;
   logic [LenExt-1:0] cur_len_x, dec_len_x, inc_len_x;
   logic [ROW_W-1:0] cur_row_o, next_row_o;
   logic [LEN_W-1:0] cur_len_o, dec_len_o, inc_len_o;

   logic      is_param, is_final, is_ctrl, is_bs, is_print, line_full;
   event_type ev;

   // Neighbor values of row and length
   assign row_next = (row_ff == RowW'(RING_ROWS - 1)) ? '0 : RowW'(row_ff + 1'b1);
   assign len_dec  = LenW'(len_ff - 1'b1);
   assign len_inc  = LenW'(len_ff + 1'b1);

   // Fit to the result field widths
   assign cur_row_x  = RowExt'(row_ff);
   assign next_row_x = RowExt'(row_next);
   assign cur_len_x  = LenExt'(len_ff);
   assign dec_len_x  = LenExt'(len_dec);
   assign inc_len_x  = LenExt'(len_inc);
   assign cur_row_o  = cur_row_x[ROW_W-1:0];
   assign next_row_o = next_row_x[ROW_W-1:0];
   assign cur_len_o  = cur_len_x[LEN_W-1:0];
   assign dec_len_o  = dec_len_x[LEN_W-1:0];
   assign inc_len_o  = inc_len_x[LEN_W-1:0];

   // Byte classes
   assign is_param  = (byte_in >= BYTE_ZERO && byte_in <= BYTE_NINE) ||
                      byte_in == BYTE_SEMI ||
                      (byte_in >= BYTE_SPACE && byte_in <= BYTE_IMED);
   assign is_final  = byte_in >= BYTE_FLO && byte_in <= BYTE_FHI;
   assign is_bs     = byte_in == BYTE_BS || byte_in == BYTE_DEL;
   assign is_ctrl   = byte_in < BYTE_SPACE && byte_in != BYTE_TAB;
   assign is_print  = !is_bs && !is_ctrl;
   assign line_full = len_ff >= LenW'(LINE_COLS);

   // Classify the byte against the current state
   always_comb begin
      ev = EV_ABSORB;
      case (phase_ff)
         PH_ESC: begin
            ev = EV_ABSORB;
         end
         PH_CSI: begin
            if (!is_param && is_final && byte_in == BYTE_K) ev = EV_CSI_CLEAR;
         end
         default: begin
            if (byte_in == BYTE_ESC || byte_in == BYTE_CR) begin
               ev = EV_ABSORB;
            end else if (byte_in == BYTE_LF) begin
               ev = EV_LF_COMMIT;
            end else if (cr_ff) begin
               ev = is_print ? EV_CR_CLEAR_PLACE : EV_CR_CLEAR;
            end else if (is_bs) begin
               ev = (len_ff != '0) ? EV_SHORTEN : EV_ABSORB;
            end else if (is_ctrl) begin
               ev = EV_ABSORB;
            end else begin
               ev = line_full ? EV_WRAP_PLACE : EV_PLACE;
            end
         end
      endcase
   end

   // Next state
   always_comb begin
      phase_in = phase_ff;
      cr_in    = cr_ff;
      len_in   = len_ff;
      row_in   = row_ff;
      case (phase_ff)
         PH_ESC:  phase_in = (byte_in == BYTE_LBRK) ? PH_CSI : PH_NORMAL;
         PH_CSI:  phase_in = is_param ? PH_CSI : PH_NORMAL;
         default: begin
            if (byte_in == BYTE_ESC) begin
               phase_in = PH_ESC;
            end else if (byte_in == BYTE_CR) begin
               cr_in = 1'b1;
            end else begin
               cr_in = 1'b0;
            end
         end
      endcase
      case (ev)
         EV_CSI_CLEAR, EV_CR_CLEAR: len_in = '0;
         EV_LF_COMMIT: begin
            len_in = '0;
            row_in = row_next;
         end
         EV_CR_CLEAR_PLACE: len_in = LenW'(1);
         EV_SHORTEN:        len_in = len_dec;
         EV_PLACE:          len_in = len_inc;
         EV_WRAP_PLACE: begin
            len_in = LenW'(1);
            row_in = row_next;
         end
         default: ;
      endcase
   end

   // Result words
   always_comb begin
      res0 = '{line_length: cur_len_o, character: '0, column: '0, row: cur_row_o,
               action: ACT_ABSORB, last: 1'b1};
      res1 = res0;
      two  = 1'b0;
      case (ev)
         EV_CSI_CLEAR, EV_CR_CLEAR: begin
            res0.action      = ACT_CLEAR;
            res0.line_length = '0;
         end
         EV_LF_COMMIT: res0.action = ACT_COMMIT;
         EV_CR_CLEAR_PLACE: begin
            res0.action      = ACT_CLEAR;
            res0.line_length = '0;
            res0.last        = 1'b0;
            res1.action      = ACT_PLACE;
            res1.character   = byte_in;
            res1.line_length = LEN_W'(1);
            two              = 1'b1;
         end
         EV_SHORTEN: begin
            res0.action      = ACT_SHORTEN;
            res0.column      = dec_len_o;
            res0.line_length = dec_len_o;
         end
         EV_PLACE: begin
            res0.action      = ACT_PLACE;
            res0.column      = cur_len_o;
            res0.character   = byte_in;
            res0.line_length = inc_len_o;
         end
         EV_WRAP_PLACE: begin
            res0.action      = ACT_COMMIT;
            res0.last        = 1'b0;
            res1.action      = ACT_PLACE;
            res1.row         = next_row_o;
            res1.character   = byte_in;
            res1.line_length = LEN_W'(1);
            two              = 1'b1;
         end
         default: ;
      endcase
   end

   // Advance the line state on each processed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NORMAL;
         cr_ff    <= 1'b0;
         len_ff   <= '0;
         row_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         cr_ff    <= cr_in;
         len_ff   <= len_in;
         row_ff   <= row_in;
      end
   end

endmodule

FILE: sv/terminal_output_byte_parser_top.sv
// Terminal output byte parser. Bytes of shell output enter on the req_ word
// channel, one per cycle while req_tready is high, and leave as row-update
// commands (absorb, place, shorten, clear, commit) on the rsp_ channel for
// an external line and history memory. Most bytes give one result word; a
// printable byte on a full line (hard wrap) or right after a CR gives two.
// A byte waits in the input register and is decoded once the result queue
// has room for two words. The rate is one byte per cycle while rsp_tready
// stays high and each byte gives one word, set by the single decode stage
// and the four-word result queue that it writes one or two words into per cycle.
module terminal_output_byte_parser_top #(
   parameter int unsigned LINE_COLS = tobp_pkg::LINE_COLS_DEF,
   parameter int unsigned RING_ROWS = tobp_pkg::RING_ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [2:0] action, [13:3] row, [20:14] column,
                                    // [28:21] character, [35:29] line_length
   output logic        rsp_tlast    // last
);
   import tobp_pkg::*;

   localparam int unsigned QDepth = 4;
   localparam int unsigned PtrW   = $clog2(QDepth);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       step;

   result_type res0, res1;
   logic       two;

   result_type          q_ff [QDepth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_ptr_nx;
   logic [PtrW:0]       count_ff, count_in;
   logic                pop;
   result_type          head;

   // Decode a held byte when the queue has room for two words
   assign step       = in_valid_ff && (count_ff <= (PtrW + 1)'(QDepth - 2));
   assign req_tready = !in_valid_ff || step;
   assign in_valid_in = (req_tvalid && req_tready) ? 1'b1 : (step ? 1'b0 : in_valid_ff);

   // Hold the input word
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   tobp_core #(
      .LINE_COLS(LINE_COLS),
      .RING_ROWS(RING_ROWS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .byte_in(in_byte_ff),
      .res0   (res0),
      .res1   (res1),
      .two    (two)
   );

   // Result queue pointers and fill
   assign pop       = rsp_tvalid && rsp_tready;
   assign wr_ptr_nx = PtrW'(wr_ptr_ff + 1'b1);
   assign rd_ptr_in = pop ? PtrW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (step) begin
         wr_ptr_in = two ? PtrW'(wr_ptr_ff + 2'd2) : wr_ptr_nx;
         count_in  = two ? (PtrW + 1)'(count_ff + 2'd2) : (PtrW + 1)'(count_ff + 1'b1);
      end
      if (pop) begin
         count_in = (PtrW + 1)'(count_in - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store one or two result words
   always_ff @(posedge clock) begin
      if (step) begin
         q_ff[wr_ptr_ff] <= res0;
         if (two) begin
            q_ff[wr_ptr_nx] <= res1;
         end
      end
   end

   // Drive the head word
   assign head       = q_ff[rd_ptr_ff];
   assign rsp_tvalid = count_ff != '0;
   assign rsp_tdata  = {4'b0, head.line_length, head.character, head.column,
                        head.row, head.action};
   assign rsp_tlast  = head.last;

endmodule
